// File: rtl/core/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Types and constants shared by the spring distance constraint pipeline.
// ----------------------------------------------------------------------------
package sdc_pkg;

	localparam int SQRT_BITS   = 34;
	localparam int SUM_W       = 66;
	localparam int LEN_W       = 34;
	localparam int EK_W        = 51;
	localparam int EK_LO_W     = 26;
	localparam int QUO_BITS    = 35;
	localparam int SCALE_SHIFT = 16;
	localparam int NUM_W       = 32 + EK_W;
	localparam int DVD_W       = NUM_W - SCALE_SHIFT;
	localparam int LATENCY     = 3 + SQRT_BITS + 3 + QUO_BITS + 1;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic [30:0]        rest_length;
		logic [16:0]        stiffness;
	} req_t;

	typedef struct packed {
		logic signed [31:0] new_a_x;
		logic signed [31:0] new_a_y;
		logic signed [31:0] new_a_z;
		logic signed [31:0] new_b_x;
		logic signed [31:0] new_b_y;
		logic signed [31:0] new_b_z;
		logic               degenerate;
	} rsp_t;

	typedef struct packed {
		logic [2:0][31:0]   a;
		logic [2:0][31:0]   b;
		logic [2:0][31:0]   m;
		logic [2:0]         neg;
		logic [30:0]        rest;
		logic [16:0]        k;
		logic               zero;
		logic [LEN_W-1:0]   len;
		logic               eneg;
	} carry_t;

endpackage

// File: rtl/core/spring_distance_constraint_top.sv
// ----------------------------------------------------------------------------
// spring_distance_constraint_top
// Fully pipelined distance constraint relaxation between two 3-D nodes.
// ----------------------------------------------------------------------------
// throughput: one request per cycle, busy is always low
// the 34 square root stages and 35 divider stages resolve one bit each
// reset clears all valid bits; data registers are not reset
module spring_distance_constraint_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sdc_pkg::req_t req,
	output logic          done,
	output sdc_pkg::rsp_t rsp
);
	import sdc_pkg::*;

	assign busy = 1'b0;

	// stage 1: differences
	logic [2:0][31:0] in_a, in_b;
	logic [2:0][31:0] mag_c;
	logic [2:0]       neg_c;
	assign in_a = {req.a_z, req.a_y, req.a_x};
	assign in_b = {req.b_z, req.b_y, req.b_x};

	always_comb begin
		logic signed [32:0] d;
		for (int i = 0; i < 3; i++) begin
			d = $signed({in_b[i][31], in_b[i]}) - $signed({in_a[i][31], in_a[i]});
			neg_c[i] = d[32];
			mag_c[i] = d[32] ? 32'(-d) : d[31:0];
		end
	end

	carry_t c0_c;
	always_comb begin
		c0_c      = '0;
		c0_c.a    = in_a;
		c0_c.b    = in_b;
		c0_c.m    = mag_c;
		c0_c.neg  = neg_c;
		c0_c.rest = req.rest_length;
		c0_c.k    = req.stiffness;
	end

	logic   v_s1, v_s2, v_s3;
	carry_t c_s1, c_s2, c_s3;
	logic [2:0][63:0]   sq_s2;
	logic [SUM_W-1:0]   sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	logic [SUM_W-1:0] sum_c;
	assign sum_c = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	carry_t c3_c;
	always_comb begin
		c3_c      = c_s2;
		c3_c.zero = (sum_c == '0);
	end

	always_ff @(posedge clk) begin
		c_s1      <= c0_c;
		for (int i = 0; i < 3; i++)
			sq_s2[i] <= 64'(c_s1.m[i]) * 64'(c_s1.m[i]);
		c_s2      <= c_s1;
		sum_s3    <= sum_c;
		c_s3      <= c3_c;
	end

	// square root, one result bit per stage
	logic                 rt_v_s   [0:SQRT_BITS];
	carry_t               rt_c_s   [0:SQRT_BITS];
	logic [SUM_W-1:0]     rt_rem_s [0:SQRT_BITS];
	logic [SQRT_BITS-1:0] rt_r_s   [0:SQRT_BITS];

	assign rt_v_s[0]   = v_s3;
	assign rt_c_s[0]   = c_s3;
	assign rt_rem_s[0] = sum_s3;
	assign rt_r_s[0]   = '0;

	for (genvar j = 0; j < SQRT_BITS; j++) begin : g_root
		localparam int B = SQRT_BITS - 1 - j;
		logic [68:0] t;
		logic        ge;
		assign t  = (69'(rt_r_s[j]) << (B + 1)) | (69'(1) << (2 * B));
		assign ge = (69'(rt_rem_s[j]) >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[j+1] <= 1'b0;
			else         rt_v_s[j+1] <= rt_v_s[j];
		end

		always_ff @(posedge clk) begin
			rt_c_s[j+1]   <= rt_c_s[j];
			rt_rem_s[j+1] <= ge ? rt_rem_s[j] - t[SUM_W-1:0] : rt_rem_s[j];
			rt_r_s[j+1]   <= ge ? (rt_r_s[j] | (SQRT_BITS'(1) << B)) : rt_r_s[j];
		end
	end

	// length error times stiffness
	logic [LEN_W-1:0] len_c;
	logic [34:0]      e_c;
	logic [LEN_W-1:0] emag_c;
	assign len_c  = rt_r_s[SQRT_BITS];
	assign e_c    = {4'b0, rt_c_s[SQRT_BITS].rest} - {1'b0, len_c};
	assign emag_c = e_c[34] ? LEN_W'(-e_c) : e_c[LEN_W-1:0];

	carry_t c4_c;
	always_comb begin
		c4_c      = rt_c_s[SQRT_BITS];
		c4_c.len  = len_c;
		c4_c.eneg = e_c[34];
	end

	logic            v_s4, v_s5;
	carry_t          c_s4, c_s5;
	logic [EK_W-1:0] ek_s4;
	logic [2:0][31+EK_LO_W:0]        pl_s5;
	logic [2:0][31+EK_W-EK_LO_W:0]   ph_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= rt_v_s[SQRT_BITS];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		c_s4      <= c4_c;
		ek_s4     <= EK_W'(emag_c) * EK_W'(rt_c_s[SQRT_BITS].k);
		c_s5      <= c_s4;
		for (int i = 0; i < 3; i++) begin
			pl_s5[i] <= (32+EK_LO_W)'(c_s4.m[i]) * (32+EK_LO_W)'(ek_s4[EK_LO_W-1:0]);
			ph_s5[i] <= (32+EK_W-EK_LO_W)'(c_s4.m[i])
				* (32+EK_W-EK_LO_W)'(ek_s4[EK_W-1:EK_LO_W]);
		end
	end

	// divider, one quotient bit per stage
	logic                      dv_v_s   [0:QUO_BITS];
	carry_t                    dv_c_s   [0:QUO_BITS];
	logic [2:0][QUO_BITS-1:0]  dv_rem_s [0:QUO_BITS];
	logic [2:0][QUO_BITS-1:0]  dv_dnd_s [0:QUO_BITS];
	logic [2:0][QUO_BITS-1:0]  dv_q_s   [0:QUO_BITS];

	logic [2:0][DVD_W-1:0] dvd_c;
	always_comb begin
		logic [NUM_W-1:0] n;
		for (int i = 0; i < 3; i++) begin
			n = NUM_W'(pl_s5[i]) + (NUM_W'(ph_s5[i]) << EK_LO_W);
			dvd_c[i] = n[NUM_W-1:SCALE_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else         dv_v_s[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		dv_c_s[0] <= c_s5;
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= QUO_BITS'(dvd_c[i][DVD_W-1:QUO_BITS]);
			dv_dnd_s[0][i] <= dvd_c[i][QUO_BITS-1:0];
			dv_q_s[0][i]   <= '0;
		end
	end

	for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
		logic [2:0][QUO_BITS-1:0] rs;
		logic [2:0]               ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rs[i] = {dv_rem_s[j][i][QUO_BITS-2:0], dv_dnd_s[j][i][QUO_BITS-1]};
				ge[i] = (rs[i] >= QUO_BITS'(dv_c_s[j].len));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else         dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			dv_c_s[j+1] <= dv_c_s[j];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[j+1][i] <= ge[i] ? rs[i] - QUO_BITS'(dv_c_s[j].len) : rs[i];
				dv_dnd_s[j+1][i] <= dv_dnd_s[j][i] << 1;
				dv_q_s[j+1][i]   <= {dv_q_s[j][i][QUO_BITS-2:0], ge[i]};
			end
		end
	end

	// apply correction and saturate; coincident nodes pass positions through
	carry_t                   fc;
	logic [2:0][QUO_BITS-1:0] fq;
	logic [2:0][31:0]         na_c, nb_c;
	assign fc = dv_c_s[QUO_BITS];
	assign fq = dv_q_s[QUO_BITS];

	always_comb begin
		logic signed [36:0] cs, na, nb;
		for (int i = 0; i < 3; i++) begin
			cs = (fc.neg[i] ^ fc.eneg) ? -$signed({2'b0, fq[i]}) : $signed({2'b0, fq[i]});
			na = $signed({{5{fc.a[i][31]}}, fc.a[i]}) - cs;
			nb = $signed({{5{fc.b[i][31]}}, fc.b[i]}) + cs;
			if (na[36:31] != {6{na[36]}}) na_c[i] = na[36] ? 32'h8000_0000 : 32'h7fff_ffff;
			else                          na_c[i] = na[31:0];
			if (nb[36:31] != {6{nb[36]}}) nb_c[i] = nb[36] ? 32'h8000_0000 : 32'h7fff_ffff;
			else                          nb_c[i] = nb[31:0];
			if (fc.zero) begin
				na_c[i] = fc.a[i];
				nb_c[i] = fc.b[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dv_v_s[QUO_BITS];
	end

	always_ff @(posedge clk) begin
		rsp.new_a_x    <= na_c[0];
		rsp.new_a_y    <= na_c[1];
		rsp.new_a_z    <= na_c[2];
		rsp.new_b_x    <= nb_c[0];
		rsp.new_b_y    <= nb_c[1];
		rsp.new_b_z    <= nb_c[2];
		rsp.degenerate <= fc.zero;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LATENCY) done)
		else $error("request did not complete at fixed latency");

	a_degen_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.degenerate) |-> (rsp.new_a_x == $past(req.a_x, LATENCY)
			&& rsp.new_b_z == $past(req.b_z, LATENCY)))
		else $error("degenerate request did not pass positions through");

	a_degen_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.degenerate == ($past(req.a_x, LATENCY) == $past(req.b_x, LATENCY)
			&& $past(req.a_y, LATENCY) == $past(req.b_y, LATENCY)
			&& $past(req.a_z, LATENCY) == $past(req.b_z, LATENCY))))
		else $error("degenerate flag does not match coincident nodes");

endmodule
